@@ sv/delt_pkg.sv @@
// Shared types and codes for the desktop-entry line tokenizer.
// Used by the top level, its port checker and the testbench files; no dependencies.
package delt_pkg;

	// Request types on the input channel
	localparam logic [1:0] REQ_CHAR = 2'd0;
	localparam logic [1:0] REQ_EOL  = 2'd1;
	localparam logic [1:0] REQ_EOF  = 2'd2;
	localparam logic [1:0] REQ_NONE = 2'd3;

	// Character roles
	localparam logic [2:0] ROLE_IGN   = 3'd0;
	localparam logic [2:0] ROLE_HEAD  = 3'd1;
	localparam logic [2:0] ROLE_KEY   = 3'd2;
	localparam logic [2:0] ROLE_LOC   = 3'd3;
	localparam logic [2:0] ROLE_VALUE = 3'd4;

	// Line kinds
	localparam logic [2:0] KIND_SKIP = 3'd0;
	localparam logic [2:0] KIND_HEAD = 3'd1;
	localparam logic [2:0] KIND_KV   = 3'd2;
	localparam logic [2:0] KIND_ERR  = 3'd3;
	localparam logic [2:0] KIND_EOF  = 3'd4;

	// Error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_TRAILING = 2'd1;
	localparam logic [1:0] ERR_NO_CLOSE = 2'd2;
	localparam logic [1:0] ERR_NO_EQ    = 2'd3;

	// Delimiter bytes
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_EQ     = 8'h3D;

	// One result record as it leaves the block
	typedef struct packed {
		logic [2:0] role;
		logic [7:0] echo;
		logic       lend;
		logic [2:0] kind;
		logic [1:0] err;
		logic       lst;
	} result_t;

endpackage

@@ sv/desktop_entry_line_tokenizer.sv @@
// Top level of the desktop-entry line tokenizer: parser state and result queue.
// Depends on delt_pkg.
//
// Takes one request per cycle while in_stall is low (a byte, an end of line
// or an end of file) and tags each byte with its role; every end of line
// yields the line kind or an error code. The parse state is updated in the
// cycle the transaction is accepted and the results are written into a
// four-entry result queue, whose head drives the output. Sustained rate is
// one request per cycle while the output side drains one result per cycle;
// the only request that yields two results is the end of file that closes
// an open line. in_stall rises when the result queue holds more than two
// entries.
module desktop_entry_line_tokenizer import delt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [7:0] char_code,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] char_role,
	output logic [7:0] char_echo,
	output logic       line_end,
	output logic [2:0] line_kind,
	output logic [1:0] error_code,
	output logic       last
);

	// Parse phases
	localparam logic [3:0] PH_LEAD     = 4'd0;
	localparam logic [3:0] PH_COMMENT  = 4'd1;
	localparam logic [3:0] PH_HEAD     = 4'd2;
	localparam logic [3:0] PH_HEADTAIL = 4'd3;
	localparam logic [3:0] PH_KEY      = 4'd4;
	localparam logic [3:0] PH_LOC      = 4'd5;
	localparam logic [3:0] PH_LOCGAP   = 4'd6;
	localparam logic [3:0] PH_KEYGAP   = 4'd7;
	localparam logic [3:0] PH_VALUE    = 4'd8;
	localparam logic [3:0] PH_ERR      = 4'd9;

	localparam int QDEPTH = 4;
	localparam int PTR_W  = $clog2(QDEPTH);
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	logic [3:0] phase_q, phase_d, ch_phase;
	logic [1:0] perr_q, perr_d, ch_perr;
	logic       open_q, open_d;
	logic       eof_q, eof_d;
	logic [2:0] ch_role;
	logic [2:0] cl_kind;
	logic [1:0] cl_err;
	logic       ws;
	logic       accept, pop;
	result_t    res0, res1;
	logic [1:0] push_n;

	result_t          queue_mem [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// Whitespace: tab through carriage return, and space
	assign ws = (char_code == 8'h20) || ((char_code >= 8'h09) && (char_code <= 8'h0D));

	// Per-byte phase step
	always_comb begin
		ch_role  = ROLE_IGN;
		ch_phase = phase_q;
		ch_perr  = perr_q;
		unique case (phase_q)
			PH_LEAD: begin
				if (!ws) begin
					priority if (char_code == CH_HASH) ch_phase = PH_COMMENT;
					else if (char_code == CH_LBRACK) ch_phase = PH_HEAD;
					else if (char_code == CH_EQ) ch_phase = PH_VALUE;
					else begin
						ch_phase = PH_KEY;
						ch_role  = ROLE_KEY;
					end
				end
			end
			PH_HEAD: begin
				if (char_code == CH_RBRACK) ch_phase = PH_HEADTAIL;
				else ch_role = ROLE_HEAD;
			end
			PH_HEADTAIL: begin
				if (!ws) begin
					ch_phase = PH_ERR;
					ch_perr  = ERR_TRAILING;
				end
			end
			PH_KEY: begin
				priority if (char_code == CH_LBRACK) ch_phase = PH_LOC;
				else if (char_code == CH_EQ) ch_phase = PH_VALUE;
				else if (ws) ch_phase = PH_KEYGAP;
				else ch_role = ROLE_KEY;
			end
			PH_LOC: begin
				if (char_code == CH_RBRACK) ch_phase = PH_LOCGAP;
				else ch_role = ROLE_LOC;
			end
			PH_LOCGAP, PH_KEYGAP: begin
				if (char_code == CH_EQ) ch_phase = PH_VALUE;
				else if (!ws) begin
					ch_phase = PH_ERR;
					ch_perr  = ERR_NO_EQ;
				end
			end
			PH_VALUE: ch_role = ROLE_VALUE;
			default: ;
		endcase
	end

	// Line close: kind and error from the phase the line ended in
	always_comb begin
		cl_err = ERR_NONE;
		unique case (phase_q)
			PH_HEADTAIL: cl_kind = KIND_HEAD;
			PH_VALUE:    cl_kind = KIND_KV;
			PH_HEAD, PH_LOC: begin
				cl_kind = KIND_ERR;
				cl_err  = ERR_NO_CLOSE;
			end
			PH_KEY, PH_LOCGAP, PH_KEYGAP: begin
				cl_kind = KIND_ERR;
				cl_err  = ERR_NO_EQ;
			end
			PH_ERR: begin
				cl_kind = KIND_ERR;
				cl_err  = perr_q;
			end
			default: cl_kind = KIND_SKIP;
		endcase
	end

	// Request decode: next state and the results it produces
	always_comb begin
		phase_d = phase_q;
		perr_d  = perr_q;
		open_d  = open_q;
		eof_d   = eof_q;
		res0    = '0;
		res1    = '0;
		push_n  = 2'd0;
		unique case (req_type)
			REQ_CHAR: begin
				push_n    = 2'd1;
				res0.echo = char_code;
				res0.lst  = 1'b1;
				if (!eof_q) begin
					res0.role = ch_role;
					phase_d   = ch_phase;
					perr_d    = ch_perr;
					open_d    = 1'b1;
				end
			end
			REQ_EOL, REQ_EOF: begin
				push_n    = 2'd1;
				res0.lend = 1'b1;
				res0.lst  = 1'b1;
				if (eof_q) begin
					res0.kind = KIND_EOF;
				end else begin
					phase_d = PH_LEAD;
					perr_d  = ERR_NONE;
					open_d  = 1'b0;
					if (req_type == REQ_EOL) begin
						res0.kind = cl_kind;
						res0.err  = cl_err;
					end else begin
						eof_d = 1'b1;
						if (open_q) begin
							push_n    = 2'd2;
							res0.kind = cl_kind;
							res0.err  = cl_err;
							res0.lst  = 1'b0;
							res1.lend = 1'b1;
							res1.kind = KIND_EOF;
							res1.lst  = 1'b1;
						end else begin
							res0.kind = KIND_EOF;
						end
					end
				end
			end
			REQ_NONE: ;
		endcase
	end

	// Handshakes
	assign in_stall  = (count_q > CNT_W'(QDEPTH - 2));
	assign accept    = in_valid && !in_stall;
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			perr_q  <= ERR_NONE;
			open_q  <= 1'b0;
			eof_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			perr_q  <= perr_d;
			open_q  <= open_d;
			eof_q   <= eof_d;
		end
	end

	// Result queue storage
	always_ff @(posedge clk) begin
		if (accept && (push_n != 2'd0)) queue_mem[wr_ptr_q] <= res0;
		if (accept && (push_n == 2'd2)) queue_mem[wr_ptr_q + PTR_W'(1)] <= res1;
	end

	// Result queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + (accept ? CNT_W'(push_n) : CNT_W'(0)) - CNT_W'(pop);
		end
	end

	// Output fields come straight from the queue head
	assign char_role  = queue_mem[rd_ptr_q].role;
	assign char_echo  = queue_mem[rd_ptr_q].echo;
	assign line_end   = queue_mem[rd_ptr_q].lend;
	assign line_kind  = queue_mem[rd_ptr_q].kind;
	assign error_code = queue_mem[rd_ptr_q].err;
	assign last       = queue_mem[rd_ptr_q].lst;

endmodule

@@ sv/delt_checker.sv @@
// Port-level checker for the desktop-entry line tokenizer, bound to the top.
// Depends on delt_pkg and desktop_entry_line_tokenizer.
module delt_checker import delt_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] req_type,
	input logic [7:0] char_code,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] char_role,
	input logic [7:0] char_echo,
	input logic       line_end,
	input logic [2:0] line_kind,
	input logic [1:0] error_code,
	input logic       last
);

	logic eof_rep_q;

	// Remembers that an end-of-file report has left the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) eof_rep_q <= 1'b0;
		else if (out_valid && !out_stall && line_end && (line_kind == KIND_EOF))
			eof_rep_q <= 1'b1;
	end

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(char_role) && $stable(char_echo)
			&& $stable(line_end) && $stable(line_kind) && $stable(error_code)
			&& $stable(last))
		else $error("result changed while stalled");

	// Line-end results carry no byte; byte results carry no line report
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (line_end ? (char_role == ROLE_IGN && char_echo == 8'h00)
			: (line_kind == KIND_SKIP && error_code == ERR_NONE && last)))
		else $error("mixed character and line-end fields");

	// Error codes only with an error line
	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code != ERR_NONE) |-> line_end && (line_kind == KIND_ERR))
		else $error("error code outside an error line");

	// End of file is sticky
	a_eof_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && eof_rep_q |-> (line_end ? (line_kind == KIND_EOF)
			: (char_role == ROLE_IGN)))
		else $error("parse activity after end of file");

	// Only an end-of-file report may follow a result that is not last
	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid && line_end
			&& (line_kind == KIND_EOF) && last)
		else $error("first of two results not followed by end of file");

endmodule

bind desktop_entry_line_tokenizer delt_checker u_delt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.req_type   (req_type),
	.char_code  (char_code),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.char_role  (char_role),
	.char_echo  (char_echo),
	.line_end   (line_end),
	.line_kind  (line_kind),
	.error_code (error_code),
	.last       (last)
);

@@ dv/delt_stream_checker.sv @@
// Result checker for the desktop-entry line tokenizer: predicts every result
// from the accepted input transactions and compares the output stream.
// Depends on delt_pkg.
`timescale 1ns / 1ps

module delt_stream_checker import delt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [7:0] char_code,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [2:0] char_role,
	input  logic [7:0] char_echo,
	input  logic       line_end,
	input  logic [2:0] line_kind,
	input  logic [1:0] error_code,
	input  logic       last,
	output int         fail_count,
	output int         results_owed
);

	// Where the scanner stands within the current line
	typedef enum logic [3:0] {
		ST_LINE_START,
		ST_COMMENT,
		ST_HEADING,
		ST_AFTER_HEADING,
		ST_KEY,
		ST_LOCALE,
		ST_AFTER_LOCALE,
		ST_BEFORE_EQ,
		ST_VALUE,
		ST_BAD_LINE
	} scan_state_t;

	scan_state_t scan_state = ST_LINE_START;
	logic [1:0]  held_err   = ERR_NONE;
	logic        line_open  = 1'b0;
	logic        eof_seen   = 1'b0;

	result_t     token_q[$];
	result_t     got;
	result_t     want;
	int          bad_results = 0;

	function automatic logic is_blank(logic [7:0] ch);
		return ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D);
	endfunction

	// Text form of one result for mismatch reports
	function automatic string show(result_t r);
		return $sformatf("role=%0d echo=%02h lend=%0d kind=%0d err=%0d last=%0d",
		                 r.role, r.echo, r.lend, r.kind, r.err, r.lst);
	endfunction

	// Advance the scanner by one byte and return the role of that byte
	function automatic logic [2:0] scan_byte(logic [7:0] ch);
		logic [2:0] role;
		role = ROLE_IGN;
		case (scan_state)
			ST_LINE_START: begin
				if (is_blank(ch))
					role = ROLE_IGN;
				else if (ch == CH_HASH)
					scan_state = ST_COMMENT;
				else if (ch == CH_LBRACK)
					scan_state = ST_HEADING;
				else if (ch == CH_EQ)
					scan_state = ST_VALUE;
				else begin
					scan_state = ST_KEY;
					role = ROLE_KEY;
				end
			end
			ST_HEADING: begin
				if (ch == CH_RBRACK)
					scan_state = ST_AFTER_HEADING;
				else
					role = ROLE_HEAD;
			end
			ST_AFTER_HEADING: begin
				if (!is_blank(ch)) begin
					held_err = ERR_TRAILING;
					scan_state = ST_BAD_LINE;
				end
			end
			ST_KEY: begin
				if (ch == CH_LBRACK)
					scan_state = ST_LOCALE;
				else if (ch == CH_EQ)
					scan_state = ST_VALUE;
				else if (is_blank(ch))
					scan_state = ST_BEFORE_EQ;
				else
					role = ROLE_KEY;
			end
			ST_LOCALE: begin
				if (ch == CH_RBRACK)
					scan_state = ST_AFTER_LOCALE;
				else
					role = ROLE_LOC;
			end
			ST_AFTER_LOCALE, ST_BEFORE_EQ: begin
				if (ch == CH_EQ)
					scan_state = ST_VALUE;
				else if (!is_blank(ch)) begin
					held_err = ERR_NO_EQ;
					scan_state = ST_BAD_LINE;
				end
			end
			ST_VALUE: role = ROLE_VALUE;
			default: role = ROLE_IGN;
		endcase
		return role;
	endfunction

	// Line end: report what the line turned out to be, then rearm
	function automatic void finish_line(output logic [2:0] kind, output logic [1:0] err);
		err = ERR_NONE;
		case (scan_state)
			ST_AFTER_HEADING: kind = KIND_HEAD;
			ST_VALUE:         kind = KIND_KV;
			ST_HEADING, ST_LOCALE: begin
				kind = KIND_ERR;
				err = ERR_NO_CLOSE;
			end
			ST_KEY, ST_AFTER_LOCALE, ST_BEFORE_EQ: begin
				kind = KIND_ERR;
				err = ERR_NO_EQ;
			end
			ST_BAD_LINE: begin
				kind = KIND_ERR;
				err = held_err;
			end
			default: kind = KIND_SKIP;
		endcase
		scan_state = ST_LINE_START;
		held_err = ERR_NONE;
		line_open = 1'b0;
	endfunction

	// Queue up the tokens that one accepted transaction should produce
	function automatic void predict_tokens(logic [1:0] req, logic [7:0] ch);
		result_t    tok;
		logic [2:0] kind;
		logic [1:0] err;
		tok = '0;
		if (req == REQ_NONE)
			return;
		if (req == REQ_CHAR) begin
			if (!eof_seen) begin
				line_open = 1'b1;
				tok.role = scan_byte(ch);
			end
			tok.echo = ch;
			tok.lst = 1'b1;
			token_q.push_back(tok);
			return;
		end
		tok.lend = 1'b1;
		tok.lst = 1'b1;
		tok.kind = KIND_EOF;
		if (eof_seen) begin
			token_q.push_back(tok);
			return;
		end
		if (req == REQ_EOL) begin
			finish_line(kind, err);
			tok.kind = kind;
			tok.err = err;
			token_q.push_back(tok);
			return;
		end
		// end of file: close a line still open first
		eof_seen = 1'b1;
		if (line_open) begin
			finish_line(kind, err);
			tok.kind = kind;
			tok.err = err;
			tok.lst = 1'b0;
			token_q.push_back(tok);
			tok.kind = KIND_EOF;
			tok.err = ERR_NONE;
			tok.lst = 1'b1;
		end else begin
			scan_state = ST_LINE_START;
			held_err = ERR_NONE;
		end
		token_q.push_back(tok);
	endfunction

	// Watch both channels on every edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_state = ST_LINE_START;
			held_err = ERR_NONE;
			line_open = 1'b0;
			eof_seen = 1'b0;
			token_q.delete();
		end else begin
			if (in_valid && !in_stall)
				predict_tokens(req_type, char_code);
			if (out_valid && !out_stall) begin
				got = '{role: char_role, echo: char_echo, lend: line_end,
				        kind: line_kind, err: error_code, lst: last};
				if (token_q.size() == 0) begin
					bad_results++;
					if (bad_results <= 10)
						$display("mismatch: result with none expected: %s", show(got));
				end else begin
					want = token_q.pop_front();
					if (got.role !== want.role || got.echo !== want.echo ||
					    got.lend !== want.lend || got.kind !== want.kind ||
					    got.err !== want.err || got.lst !== want.lst) begin
						bad_results++;
						if (bad_results <= 10) begin
							$display("mismatch: expected %s", show(want));
							$display("          actual   %s", show(got));
						end
					end
				end
			end
		end
		fail_count <= bad_results;
		results_owed <= token_q.size();
	end

endmodule

@@ dv/tb_top.sv @@
// Testbench top for the desktop-entry line tokenizer: clock, reset, stimulus
// and verdict. Depends on delt_pkg, desktop_entry_line_tokenizer and
// delt_stream_checker.
`timescale 1ns / 1ps

module tb_top;
	import delt_pkg::*;

	localparam int TEXT_ITEMS  = 1800;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_AT     = 900;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 20;

	typedef struct packed {
		logic [1:0] req;
		logic [7:0] ch;
	} request_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] req_type;
	logic [7:0] char_code;
	logic       out_valid;
	logic       out_stall;
	logic [2:0] char_role;
	logic [7:0] char_echo;
	logic       line_end;
	logic [2:0] line_kind;
	logic [1:0] error_code;
	logic       last;

	int         fail_count;
	int         results_owed;
	int         cycle_count = 0;
	bit         hold_pending = 1'b0;
	request_t   request_q[$];
	int         text_items = 0;

	desktop_entry_line_tokenizer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.char_code  (char_code),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.char_role  (char_role),
		.char_echo  (char_echo),
		.line_end   (line_end),
		.line_kind  (line_kind),
		.error_code (error_code),
		.last       (last)
	);

	delt_stream_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.char_code    (char_code),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.char_role    (char_role),
		.char_echo    (char_echo),
		.line_end     (line_end),
		.line_kind    (line_kind),
		.error_code   (error_code),
		.last         (last),
		.fail_count   (fail_count),
		.results_owed (results_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Request builders
	function automatic void add_request(logic [1:0] req, logic [7:0] ch);
		request_q.push_back('{req: req, ch: ch});
		if (req != REQ_NONE)
			text_items++;
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_request(REQ_CHAR, s[i]);
	endfunction

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] blank_byte();
		int pick;
		pick = $urandom_range(0, 5);
		return (pick == 5) ? 8'h20 : 8'(8'h09 + pick);
	endfunction

	// A byte that keeps a key going: no blank and no delimiter
	function automatic logic [7:0] word_byte();
		logic [7:0] ch;
		do
			ch = any_byte();
		while (ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D) || ch == CH_LBRACK ||
		       ch == CH_RBRACK || ch == CH_EQ || ch == CH_HASH);
		return ch;
	endfunction

	// Any byte but the closing bracket
	function automatic logic [7:0] bracket_byte();
		logic [7:0] ch;
		do
			ch = any_byte();
		while (ch == CH_RBRACK);
		return ch;
	endfunction

	function automatic void add_blanks(int lo, int hi);
		repeat ($urandom_range(lo, hi))
			add_request(REQ_CHAR, blank_byte());
	endfunction

	// One random line, mostly well formed, ended by an end of line
	function automatic void add_random_line();
		int shape;
		int line_start;
		line_start = request_q.size();
		shape = $urandom_range(0, 15);
		if ($urandom_range(0, 3) == 0)
			add_blanks(1, 3);
		case (shape)
			0, 1, 2: begin
				add_request(REQ_CHAR, CH_LBRACK);
				repeat ($urandom_range(0, 8))
					add_request(REQ_CHAR, bracket_byte());
				add_request(REQ_CHAR, CH_RBRACK);
				add_blanks(0, 2);
			end
			3, 4, 5, 6: begin
				repeat ($urandom_range(1, 6))
					add_request(REQ_CHAR, word_byte());
				if ($urandom_range(0, 2) == 0) begin
					add_request(REQ_CHAR, CH_LBRACK);
					repeat ($urandom_range(0, 4))
						add_request(REQ_CHAR, bracket_byte());
					add_request(REQ_CHAR, CH_RBRACK);
				end
				add_blanks(0, 2);
				add_request(REQ_CHAR, CH_EQ);
				repeat ($urandom_range(0, 10))
					add_request(REQ_CHAR, any_byte());
			end
			7: begin
				add_request(REQ_CHAR, CH_HASH);
				repeat ($urandom_range(0, 8))
					add_request(REQ_CHAR, any_byte());
			end
			8: add_blanks(0, 2);
			9: begin
				add_request(REQ_CHAR, CH_EQ);
				repeat ($urandom_range(0, 6))
					add_request(REQ_CHAR, any_byte());
			end
			10: begin
				add_request(REQ_CHAR, CH_LBRACK);
				repeat ($urandom_range(0, 4))
					add_request(REQ_CHAR, bracket_byte());
				add_request(REQ_CHAR, CH_RBRACK);
				add_blanks(0, 2);
				add_request(REQ_CHAR, word_byte());
				repeat ($urandom_range(0, 4))
					add_request(REQ_CHAR, any_byte());
			end
			11, 12: begin
				// key followed by something other than '='
				repeat ($urandom_range(1, 4))
					add_request(REQ_CHAR, word_byte());
				if ($urandom_range(0, 1) == 0) begin
					add_request(REQ_CHAR, CH_LBRACK);
					add_request(REQ_CHAR, bracket_byte());
					add_request(REQ_CHAR, CH_RBRACK);
				end
				add_blanks(0, 2);
				if ($urandom_range(0, 1) == 0)
					add_request(REQ_CHAR, word_byte());
				repeat ($urandom_range(0, 3))
					add_request(REQ_CHAR, any_byte());
			end
			default: begin
				// noise, including ignored requests
				repeat ($urandom_range(1, 12)) begin
					case ($urandom_range(0, 5))
						0:       add_request(REQ_EOL, any_byte());
						1:       add_request(REQ_NONE, any_byte());
						default: add_request(REQ_CHAR, any_byte());
					endcase
				end
			end
		endcase
		// now and then cut a line short
		if (shape <= 6 && $urandom_range(0, 7) == 0) begin
			int cut;
			cut = $urandom_range(line_start, request_q.size());
			while (request_q.size() > cut) begin
				if (request_q[$].req != REQ_NONE)
					text_items--;
				void'(request_q.pop_back());
			end
		end
		if ($urandom_range(0, 15) == 0)
			add_request(REQ_NONE, any_byte());
		add_request(REQ_EOL, any_byte());
	endfunction

	// Receiver stall pattern, with one long hold-off
	initial begin
		int mode;
		int span;
		bit hold_done;
		hold_done = 1'b0;
		out_stall <= 1'b0;
		wait (arst_n);
		forever begin
			if (hold_pending && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 80);
			repeat (span) begin
				case (mode)
					0:       out_stall <= 1'b0;
					1:       out_stall <= ($urandom_range(0, 1) == 1);
					2:       out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 4) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int sent;
		int gap;
		int burst;
		in_valid <= 1'b0;
		req_type <= REQ_NONE;
		char_code <= 8'h00;

		// directed lines
		add_text("[Sec]");
		add_request(REQ_EOL, 8'h00);
		add_text("#");
		add_request(REQ_CHAR, 8'h00);
		add_request(REQ_EOL, 8'hFF);
		add_text(" k[l] =");
		add_request(REQ_CHAR, 8'hFF);
		add_request(REQ_EOL, 8'h00);
		add_text("[a]b");
		add_request(REQ_EOL, 8'h00);
		add_text("k x");
		add_request(REQ_EOL, 8'h00);
		add_text("[a");
		add_request(REQ_EOL, 8'h00);
		add_request(REQ_NONE, 8'hFF);
		add_request(REQ_EOL, 8'h00);

		// random lines; end of file is sticky so it only comes at the very end
		while (text_items < TEXT_ITEMS)
			add_random_line();

		// end of file inside an open line, then traffic after end of file
		add_text("k");
		add_request(REQ_EOF, 8'h00);
		add_request(REQ_CHAR, CH_LBRACK);
		add_request(REQ_EOL, 8'h00);
		add_request(REQ_EOF, 8'h00);
		add_request(REQ_NONE, 8'h00);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// send in bursts with random gaps
		sent = 0;
		while (sent < request_q.size()) begin
			burst = $urandom_range(1, 24);
			for (int n = 0; n < burst && sent < request_q.size(); n++) begin
				in_valid <= 1'b1;
				req_type <= request_q[sent].req;
				char_code <= request_q[sent].ch;
				do
					@(posedge clk);
				while (in_stall);
				sent++;
				if (sent == HOLD_AT)
					hold_pending = 1'b1;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;

		// drain, then let the pipeline settle
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0 && results_owed == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ sim.f @@
sv/delt_pkg.sv
sv/desktop_entry_line_tokenizer.sv
sv/delt_checker.sv
dv/delt_stream_checker.sv
dv/tb_top.sv
